### src/rcv_pkg.sv
`default_nettype none

package rcv_pkg;

   localparam int CMD_W        = 64;
   localparam int COMBINER_W   = 56;
   localparam int ERR_FLAGS_W  = 11;
   localparam int ERR_COUNT_W  = 4;
   localparam int CMD_WORDS_W  = 5;
   localparam int TOTAL_OUT_W  = 16;
   localparam int TOTAL_WIDTH_DEFAULT = 16;

   localparam int OPCODE_LO = 56;
   localparam int OPCODE_HI = 61;

   localparam logic [5:0] OP_SET_OTHER_MODES = 6'h2F;
   localparam logic [5:0] OP_SET_COMBINE     = 6'h3C;
   localparam logic [5:0] OP_SET_SCISSOR     = 6'h2D;
   localparam logic [5:0] OP_TEX_RECT_FLIP   = 6'h25;
   localparam logic [5:0] OP_TEX_RECT        = 6'h24;
   localparam logic [5:0] OP_FILL_RECT       = 6'h36;
   localparam logic [5:0] OP_TRI_FIRST       = 6'h08;
   localparam logic [5:0] OP_TRI_Z           = 6'h09;
   localparam logic [5:0] OP_TRI_TEX         = 6'h0A;
   localparam logic [5:0] OP_TRI_TEX_Z       = 6'h0B;
   localparam logic [5:0] OP_TRI_SHADE       = 6'h0C;
   localparam logic [5:0] OP_TRI_SHADE_Z     = 6'h0D;
   localparam logic [5:0] OP_TRI_SHADE_TEX_Z = 6'h0F;
   localparam logic [5:0] OP_TRI_SHADE_TEX   = 6'h0E;

   localparam logic [1:0] CM_ONE_CYCLE = 2'd0;
   localparam logic [1:0] CM_TWO_CYCLE = 2'd1;

   localparam logic [2:0] SLOT_COMBINED = 3'd0;
   localparam logic [2:0] SLOT_TEX0     = 3'd1;
   localparam logic [2:0] SLOT_TEX1     = 3'd2;
   localparam logic [2:0] SLOT_SHADE    = 3'd4;

   localparam int ERR_MODE        = 0;
   localparam int ERR_NO_COMBINE  = 1;
   localparam int ERR_1C_COMBINED = 2;
   localparam int ERR_1C_TEX1     = 3;
   localparam int ERR_2C_COMBINED = 4;
   localparam int ERR_2C_TEX1     = 5;
   localparam int ERR_NO_SCISSOR  = 6;
   localparam int ERR_TEX0_UNTEX  = 7;
   localparam int ERR_TEX1_UNTEX  = 8;
   localparam int ERR_SHADE_FLAT  = 9;
   localparam int ERR_PERSP_NO_W  = 10;

   typedef struct packed {
      logic                  scissor_seen;
      logic                  mode_dirty;
      logic                  combine_seen;
      logic [1:0]            cycle_mode;
      logic                  perspective_on;
      logic [COMBINER_W-1:0] combiner_bits;
   } rcv_state_type;

   typedef struct packed {
      logic [ERR_FLAGS_W-1:0] error_flags;
      logic [ERR_COUNT_W-1:0] error_count;
      logic                   warning_count;
      logic [CMD_WORDS_W-1:0] command_words;
   } rcv_check_type;

   typedef struct packed {
      logic [3:0] rgb_minuend;
      logic [3:0] rgb_subtrahend;
      logic [4:0] rgb_mul;
      logic [2:0] rgb_add;
      logic [2:0] a_suba;
      logic [2:0] a_subb;
      logic [2:0] a_mul;
      logic [2:0] a_add;
   } rcv_slots_type;

   function automatic rcv_slots_type get_slots(input logic [COMBINER_W-1:0] c,
                                               input logic cyc);
      rcv_slots_type s;
      if (!cyc) begin
         s.rgb_minuend    = c[55:52];
         s.rgb_subtrahend = c[31:28];
         s.rgb_mul        = c[51:47];
         s.rgb_add        = c[17:15];
         s.a_suba         = c[46:44];
         s.a_subb         = c[14:12];
         s.a_mul          = c[43:41];
         s.a_add          = c[11:9];
      end else begin
         s.rgb_minuend    = c[40:37];
         s.rgb_subtrahend = c[27:24];
         s.rgb_mul        = c[36:32];
         s.rgb_add        = c[8:6];
         s.a_suba         = c[23:21];
         s.a_subb         = c[5:3];
         s.a_mul          = c[20:18];
         s.a_add          = c[2:0];
      end
      return s;
   endfunction

   function automatic logic slot_uses(input rcv_slots_type s, input logic [2:0] v);
      return (s.rgb_minuend == 4'(v)) || (s.rgb_subtrahend == 4'(v)) ||
             (s.rgb_mul == 5'(v)) || (s.rgb_add == v) ||
             (s.a_suba == v) || (s.a_subb == v) ||
             (s.a_mul == v) || (s.a_add == v);
   endfunction

   function automatic logic [CMD_WORDS_W-1:0] cmd_words(input logic [5:0] op);
      logic [CMD_WORDS_W-1:0] n;
      case (op)
         OP_TEX_RECT, OP_TEX_RECT_FLIP:  n = 5'd2;
         OP_TRI_FIRST:                   n = 5'd4;
         OP_TRI_Z:                       n = 5'd6;
         OP_TRI_TEX, OP_TRI_SHADE:       n = 5'd12;
         OP_TRI_TEX_Z, OP_TRI_SHADE_Z:   n = 5'd14;
         OP_TRI_SHADE_TEX:               n = 5'd20;
         OP_TRI_SHADE_TEX_Z:             n = 5'd22;
         default:                        n = 5'd1;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

### src/rcv_if.sv
`default_nettype none

interface rcv_req_if;
   logic                     valid;
   logic                     ready;
   logic [rcv_pkg::CMD_W-1:0] command_word;

   modport source (output valid, output command_word, input ready);
   modport sink   (input valid, input command_word, output ready);
endinterface

interface rcv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rcv_pkg::ERR_FLAGS_W-1:0]  error_flags;
   logic [rcv_pkg::ERR_COUNT_W-1:0]  error_count;
   logic                             warning_count;
   logic [rcv_pkg::CMD_WORDS_W-1:0]  command_words;
   logic [rcv_pkg::TOTAL_OUT_W-1:0]  total_errors;
   logic [rcv_pkg::TOTAL_OUT_W-1:0]  total_warnings;

   modport source (output valid, output error_flags, output error_count,
                   output warning_count, output command_words,
                   output total_errors, output total_warnings, input ready);
   modport sink   (input valid, input error_flags, input error_count,
                   input warning_count, input command_words,
                   input total_errors, input total_warnings, output ready);
endinterface

`default_nettype wire

### src/rcv_checker.sv
`default_nettype none

module rcv_checker (
   input  wire logic [rcv_pkg::CMD_W-1:0] command_word,
   input  wire rcv_pkg::rcv_state_type    state,
   output rcv_pkg::rcv_state_type         state_next,
   output rcv_pkg::rcv_check_type         check
);
   import rcv_pkg::*;

   logic [5:0]             op;
   logic                   is_tri, is_rect, is_draw;
   logic                   colors, tex, z;
   logic                   copy_fill;
   logic                   lazy_run;
   rcv_slots_type          c0, c1;
   logic                   c0_active;
   logic [ERR_FLAGS_W-1:0] flags;
   logic                   warn;
   logic                   t0_c0, t0_c1, t1_c0, t1_c1, sh_c0, sh_c1;

   assign op        = command_word[OPCODE_HI:OPCODE_LO];
   assign is_tri    = (op[5:3] == OP_TRI_FIRST[5:3]);
   assign is_rect   = (op == OP_TEX_RECT) || (op == OP_TEX_RECT_FLIP) || (op == OP_FILL_RECT);
   assign is_draw   = is_tri || is_rect;
   assign colors    = is_tri && op[2];
   assign tex       = is_tri ? op[1] : (op != OP_FILL_RECT);
   assign z         = is_tri && op[0];
   assign copy_fill = state.cycle_mode[1];
   assign lazy_run  = is_draw && state.mode_dirty && !copy_fill;
   assign c0        = get_slots(state.combiner_bits, 1'b0);
   assign c1        = get_slots(state.combiner_bits, 1'b1);
   assign c0_active = (state.cycle_mode == CM_TWO_CYCLE);

   // per-cycle slot checks, only meaningful outside copy/fill mode
   always_comb begin
      t0_c0 = is_draw && !copy_fill && !tex && c0_active && slot_uses(c0, SLOT_TEX0);
      t0_c1 = is_draw && !copy_fill && !tex && slot_uses(c1, SLOT_TEX0);
      t1_c0 = is_draw && !copy_fill && !tex && c0_active && slot_uses(c0, SLOT_TEX1);
      t1_c1 = is_draw && !copy_fill && !tex && slot_uses(c1, SLOT_TEX1);
      sh_c0 = is_draw && !copy_fill && !colors && c0_active && slot_uses(c0, SLOT_SHADE);
      sh_c1 = is_draw && !copy_fill && !colors && slot_uses(c1, SLOT_SHADE);
   end

   always_comb begin
      flags = '0;
      warn  = 1'b0;
      flags[ERR_MODE] = copy_fill && (is_tri || (op == OP_TEX_RECT_FLIP));
      if (lazy_run) begin
         if (!state.combine_seen) begin
            flags[ERR_NO_COMBINE] = 1'b1;
         end else if (state.cycle_mode == CM_ONE_CYCLE) begin
            warn = (c0 != c1);
            flags[ERR_1C_COMBINED] = slot_uses(c1, SLOT_COMBINED);
            flags[ERR_1C_TEX1]     = slot_uses(c1, SLOT_TEX1);
         end else begin
            flags[ERR_2C_COMBINED] = slot_uses(c0, SLOT_COMBINED);
            flags[ERR_2C_TEX1]     = slot_uses(c1, SLOT_TEX1);
         end
      end
      flags[ERR_NO_SCISSOR] = is_draw && !state.scissor_seen;
      flags[ERR_TEX0_UNTEX] = t0_c0 || t0_c1;
      flags[ERR_TEX1_UNTEX] = t1_c0 || t1_c1;
      flags[ERR_SHADE_FLAT] = sh_c0 || sh_c1;
      flags[ERR_PERSP_NO_W] = is_draw && !copy_fill && tex && !z && state.perspective_on;
   end

   always_comb begin
      check.error_flags   = flags;
      check.warning_count = warn;
      check.command_words = cmd_words(op);
      check.error_count   = 4'(flags[ERR_MODE]) + 4'(flags[ERR_NO_COMBINE]) +
                            4'(flags[ERR_1C_COMBINED]) + 4'(flags[ERR_1C_TEX1]) +
                            4'(flags[ERR_2C_COMBINED]) + 4'(flags[ERR_2C_TEX1]) +
                            4'(flags[ERR_NO_SCISSOR]) + 4'(flags[ERR_PERSP_NO_W]) +
                            4'(t0_c0) + 4'(t0_c1) + 4'(t1_c0) + 4'(t1_c1) +
                            4'(sh_c0) + 4'(sh_c1);
   end

   always_comb begin
      state_next = state;
      case (op)
         OP_SET_OTHER_MODES: begin
            state_next.cycle_mode     = command_word[53:52];
            state_next.perspective_on = command_word[51];
            state_next.mode_dirty     = 1'b1;
         end
         OP_SET_COMBINE: begin
            state_next.combiner_bits = command_word[COMBINER_W-1:0];
            state_next.combine_seen  = 1'b1;
            state_next.mode_dirty    = 1'b1;
         end
         OP_SET_SCISSOR: begin
            state_next.scissor_seen = 1'b1;
         end
         default: begin
            // the lazy check runs at most once per mode or combine change
            if (is_draw) begin
               state_next.mode_dirty = 1'b0;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

### src/rcv_totals.sv
`default_nettype none

module rcv_totals #(
   parameter int TOTAL_WIDTH = rcv_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic [rcv_pkg::ERR_COUNT_W-1:0]  error_count,
   input  wire logic                             warning_count,
   output logic      [rcv_pkg::TOTAL_OUT_W-1:0]  total_errors_next,
   output logic      [rcv_pkg::TOTAL_OUT_W-1:0]  total_warnings_next
);
   import rcv_pkg::*;

   localparam int ViewW = (TOTAL_WIDTH < TOTAL_OUT_W) ? TOTAL_WIDTH : TOTAL_OUT_W;

   logic [TOTAL_WIDTH-1:0] err_total_ff, err_total_in;
   logic [TOTAL_WIDTH-1:0] warn_total_ff, warn_total_in;
   logic [TOTAL_WIDTH:0]   err_sum, warn_sum;

   assign err_sum  = {1'b0, err_total_ff} + (TOTAL_WIDTH + 1)'(error_count);
   assign warn_sum = {1'b0, warn_total_ff} + (TOTAL_WIDTH + 1)'(warning_count);

   // saturate on carry out
   assign err_total_in  = err_sum[TOTAL_WIDTH] ? '1 : err_sum[TOTAL_WIDTH-1:0];
   assign warn_total_in = warn_sum[TOTAL_WIDTH] ? '1 : warn_sum[TOTAL_WIDTH-1:0];

   assign total_errors_next   = TOTAL_OUT_W'(err_total_in[ViewW-1:0]);
   assign total_warnings_next = TOTAL_OUT_W'(warn_total_in[ViewW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         err_total_ff  <= '0;
         warn_total_ff <= '0;
      end else if (advance) begin
         err_total_ff  <= err_total_in;
         warn_total_ff <= warn_total_in;
      end
   end

endmodule

`default_nettype wire

### src/render_command_validator.sv
`default_nettype none
// Commands pass through an input register, then an output register for results.
// Throughput: one item per cycle while the response side is ready; the input
// register refills while a result waits in the output register, and the state
// update for one command is combinational compares ahead of the next.
// Reset (synchronous) clears the tracked mode, combiner, scissor state and totals.

module render_command_validator #(
   parameter int TOTAL_WIDTH = rcv_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   rcv_req_if.sink   req_ch,
   rcv_rsp_if.source rsp_ch
);
   import rcv_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic               out_valid_ff, out_valid_in;
   logic               advance;
   rcv_state_type      state_ff, state_in;
   rcv_check_type      check;
   rcv_check_type      check_ff;
   logic [TOTAL_OUT_W-1:0] err_total_next, warn_total_next;
   logic [TOTAL_OUT_W-1:0] err_total_ff, warn_total_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   rcv_checker u_checker (
      .command_word (cmd_ff),
      .state        (state_ff),
      .state_next   (state_in),
      .check        (check)
   );

   rcv_totals #(
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_totals (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .error_count         (check.error_count),
      .warning_count       (check.warning_count),
      .total_errors_next   (err_total_next),
      .total_warnings_next (warn_total_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff <= req_ch.command_word;
      end
      if (advance) begin
         check_ff      <= check;
         err_total_ff  <= err_total_next;
         warn_total_ff <= warn_total_next;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.error_flags    = check_ff.error_flags;
   assign rsp_ch.error_count    = check_ff.error_count;
   assign rsp_ch.warning_count  = check_ff.warning_count;
   assign rsp_ch.command_words  = check_ff.command_words;
   assign rsp_ch.total_errors   = err_total_ff;
   assign rsp_ch.total_warnings = warn_total_ff;

endmodule

`default_nettype wire

### tb/validator_scoreboard.sv
`timescale 1ns / 1ps

module validator_scoreboard #(
   parameter int TOTAL_WIDTH = rcv_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rcv_req_if   req,
   rcv_rsp_if   rsp,
   output int   pending,
   output int   mismatches,
   output int   checked
);
   import rcv_pkg::*;

   typedef struct packed {
      logic [ERR_FLAGS_W-1:0] flags;
      logic [ERR_COUNT_W-1:0] count;
      logic                   warn;
      logic [CMD_WORDS_W-1:0] words;
      logic [TOTAL_OUT_W-1:0] err_total;
      logic [TOTAL_OUT_W-1:0] warn_total;
   } verdict_type;

   localparam longint TOTAL_MAX = (longint'(1) << TOTAL_WIDTH) - 1;

   logic                   scissor_seen = 1'b0;
   logic                   combine_seen = 1'b0;
   logic                   mode_dirty   = 1'b0;
   logic                   persp_on     = 1'b0;
   logic [1:0]             cycle_mode   = '0;
   logic [COMBINER_W-1:0]  combiner     = '0;
   longint                 err_total    = 0;
   longint                 warn_total   = 0;

   logic [ERR_FLAGS_W-1:0] step_flags;
   int                     step_count;
   logic                   step_warn;

   verdict_type            expected_verdicts[$];

   function automatic void clear_tracking();
      scissor_seen = 1'b0;
      combine_seen = 1'b0;
      mode_dirty   = 1'b0;
      persp_on     = 1'b0;
      cycle_mode   = '0;
      combiner     = '0;
      err_total    = 0;
      warn_total   = 0;
   endfunction

   // {rgb suba, subb, mul, add, alpha suba, subb, mul, add} of one combiner cycle
   function automatic logic [27:0] cycle_fields(logic cyc);
      if (!cyc)
         return {combiner[55:52], combiner[31:28], combiner[51:47], combiner[17:15],
                 combiner[46:44], combiner[14:12], combiner[43:41], combiner[11:9]};
      return {combiner[40:37], combiner[27:24], combiner[36:32], combiner[8:6],
              combiner[23:21], combiner[5:3], combiner[20:18], combiner[2:0]};
   endfunction

   function automatic logic cycle_uses(logic cyc, logic [2:0] slot);
      logic [27:0] f;
      f = cycle_fields(cyc);
      return f[27:24] == slot || f[23:20] == slot || f[19:15] == slot || f[14:12] == slot ||
             f[11:9] == slot || f[8:6] == slot || f[5:3] == slot || f[2:0] == slot;
   endfunction

   function automatic void flag_error(int b);
      step_flags[b] = 1'b1;
      step_count++;
   endfunction

   // combiner rules are checked on the first draw after a mode or combine change, unless in copy or fill mode
   function automatic void settle_mode();
      if (!mode_dirty) return;
      mode_dirty = 1'b0;
      if (cycle_mode[1]) return;
      if (!combine_seen) begin
         flag_error(ERR_NO_COMBINE);
         return;
      end
      if (cycle_mode == CM_ONE_CYCLE) begin
         step_warn = cycle_fields(1'b0) != cycle_fields(1'b1);
         if (cycle_uses(1'b1, SLOT_COMBINED)) flag_error(ERR_1C_COMBINED);
         if (cycle_uses(1'b1, SLOT_TEX1)) flag_error(ERR_1C_TEX1);
      end else begin
         if (cycle_uses(1'b0, SLOT_COMBINED)) flag_error(ERR_2C_COMBINED);
         if (cycle_uses(1'b1, SLOT_TEX1)) flag_error(ERR_2C_TEX1);
      end
   endfunction

   function automatic void check_draw(logic shaded, logic textured, logic has_z);
      int cyc;
      if (!scissor_seen) flag_error(ERR_NO_SCISSOR);
      // copy and fill modes skip the slot and perspective rules
      if (cycle_mode[1]) return;
      for (cyc = (cycle_mode == CM_ONE_CYCLE) ? 1 : 0; cyc < 2; cyc++) begin
         if (!textured && cycle_uses(cyc[0], SLOT_TEX0)) flag_error(ERR_TEX0_UNTEX);
         if (!textured && cycle_uses(cyc[0], SLOT_TEX1)) flag_error(ERR_TEX1_UNTEX);
         if (!shaded && cycle_uses(cyc[0], SLOT_SHADE)) flag_error(ERR_SHADE_FLAT);
      end
      if (textured && !has_z && persp_on) flag_error(ERR_PERSP_NO_W);
   endfunction

   function automatic verdict_type predict_command(logic [CMD_W-1:0] w);
      logic [5:0]  op;
      verdict_type v;
      op = w[OPCODE_HI:OPCODE_LO];
      step_flags = '0;
      step_count = 0;
      step_warn  = 1'b0;
      v.words    = 5'd1;
      if (op >= OP_TRI_FIRST && op <= OP_TRI_SHADE_TEX_Z) begin
         if (cycle_mode[1]) flag_error(ERR_MODE);
         settle_mode();
         check_draw(op[2], op[1], op[0]);
         // header plus edge words, then shade, texture and depth coefficient blocks
         v.words = 5'd4 + (op[2] ? 5'd8 : 5'd0) + (op[1] ? 5'd8 : 5'd0) + (op[0] ? 5'd2 : 5'd0);
      end else begin
         case (op)
            OP_SET_OTHER_MODES: begin
               cycle_mode = w[53:52];
               persp_on   = w[51];
               mode_dirty = 1'b1;
            end
            OP_SET_COMBINE: begin
               combiner     = w[COMBINER_W-1:0];
               combine_seen = 1'b1;
               mode_dirty   = 1'b1;
            end
            OP_SET_SCISSOR: begin
               scissor_seen = 1'b1;
            end
            OP_TEX_RECT, OP_TEX_RECT_FLIP: begin
               if (op == OP_TEX_RECT_FLIP && cycle_mode[1]) flag_error(ERR_MODE);
               settle_mode();
               check_draw(1'b0, 1'b1, 1'b0);
               v.words = 5'd2;
            end
            OP_FILL_RECT: begin
               settle_mode();
               check_draw(1'b0, 1'b0, 1'b0);
            end
            default: ;
         endcase
      end
      err_total += step_count;
      if (err_total > TOTAL_MAX) err_total = TOTAL_MAX;
      warn_total += step_warn;
      if (warn_total > TOTAL_MAX) warn_total = TOTAL_MAX;
      v.flags      = step_flags;
      v.count      = step_count[ERR_COUNT_W-1:0];
      v.warn       = step_warn;
      v.err_total  = err_total[TOTAL_OUT_W-1:0];
      v.warn_total = warn_total[TOTAL_OUT_W-1:0];
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type got;
      if (reset) begin
         clear_tracking();
         expected_verdicts.delete();
      end else begin
         if (req.valid && req.ready)
            expected_verdicts.push_back(predict_command(req.command_word));
         if (rsp.valid && rsp.ready) begin
            got = {rsp.error_flags, rsp.error_count, rsp.warning_count, rsp.command_words,
                   rsp.total_errors, rsp.total_warnings};
            checked++;
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with no command outstanding: flags %h", checked,
                           got.flags);
            end else begin
               want = expected_verdicts.pop_front();
               if (want.flags !== got.flags || want.count !== got.count ||
                   want.warn !== got.warn || want.words !== got.words ||
                   want.err_total !== got.err_total || want.warn_total !== got.warn_total) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d expected: flags %h count %0d warn %0d words %0d totals %0d/%0d",
                              checked, want.flags, want.count, want.warn, want.words,
                              want.err_total, want.warn_total);
                     $display("result %0d actual:   flags %h count %0d warn %0d words %0d totals %0d/%0d",
                              checked, got.flags, got.count, got.warn, got.words,
                              got.err_total, got.warn_total);
                  end
               end
            end
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

### tb/render_command_validator_test.sv
`timescale 1ns / 1ps

module render_command_validator_test;
   import rcv_pkg::*;

   localparam int         RANDOM_ITEMS = 1400;
   localparam int         CYCLE_LIMIT  = 600000;
   localparam logic [1:0] CM_COPY      = 2'd2;
   localparam logic [1:0] CM_FILL      = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   pending;
   int   mismatches;
   int   checked;
   int   cycle_count = 0;
   bit   steady      = 1'b0;
   int   draws_sent  = 0;
   int   setup_sent  = 0;
   int   noise_sent  = 0;
   int   random_sent = 0;
   int   drains      = 0;

   rcv_req_if req_ch();
   rcv_rsp_if rsp_ch();

   render_command_validator #(.TOTAL_WIDTH(TOTAL_WIDTH_DEFAULT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   validator_scoreboard #(.TOTAL_WIDTH(TOTAL_WIDTH_DEFAULT)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .pending    (pending),
      .mismatches (mismatches),
      .checked    (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("render_command_validator_test: done, errors");
      $finish;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_length();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(3) == 0) stall = idle_length();
         end
      end
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] with_opcode(logic [5:0] op, logic [63:0] body);
      return {body[63:62], op, body[55:0]};
   endfunction

   function automatic logic [63:0] modes_word(logic [1:0] mode, logic persp, logic [63:0] body);
      return with_opcode(OP_SET_OTHER_MODES, {body[63:54], mode, persp, body[50:0]});
   endfunction

   function automatic logic [5:0] tri_opcode(logic shaded, logic textured, logic has_z);
      return OP_TRI_FIRST | {3'b000, shaded, textured, has_z};
   endfunction

   // sparse patterns land many slots on combined, texel and shade inputs
   function automatic logic [63:0] combine_body();
      logic [63:0] r1;
      logic [63:0] r2;
      logic [63:0] r3;
      r1 = random_word();
      r2 = random_word();
      r3 = random_word();
      case ($urandom_range(3))
         0:       return r1;
         1:       return r1 & r2;
         2:       return r1 & r2 & r3;
         default: return r1 | r2;
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(9);
      if (r < 4) return CM_ONE_CYCLE;
      if (r < 8) return CM_TWO_CYCLE;
      if (r == 8) return CM_COPY;
      return CM_FILL;
   endfunction

   function automatic logic [5:0] draw_opcode();
      int r;
      r = $urandom_range(10);
      case (r)
         0:       return OP_TEX_RECT;
         1:       return OP_TEX_RECT_FLIP;
         2:       return OP_FILL_RECT;
         default: return tri_opcode(r[2] ^ r[0] ^ 1'b1, r[1], r[0]);
      endcase
   endfunction

   task automatic send(logic [63:0] w);
      logic [5:0] op;
      int         gap;
      op = w[OPCODE_HI:OPCODE_LO];
      req_ch.command_word = w;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if ((op >= OP_TRI_FIRST && op <= OP_TRI_SHADE_TEX_Z) || op == OP_TEX_RECT ||
          op == OP_TEX_RECT_FLIP || op == OP_FILL_RECT)
         draws_sent++;
      else if (op == OP_SET_OTHER_MODES || op == OP_SET_COMBINE || op == OP_SET_SCISSOR)
         setup_sent++;
      else
         noise_sent++;
      @(negedge clock);
      gap = idle_length();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         req_ch.command_word = random_word();
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold the sender until every result is back
   task automatic drain();
      req_ch.valid = 1'b0;
      drains++;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic play_scene();
      int n;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(3, 1)) send(random_word());
      end
      if ($urandom_range(9) != 0) begin
         send(with_opcode(OP_SET_SCISSOR, random_word()));
         random_sent++;
      end
      if ($urandom_range(4) != 0) begin
         send(modes_word(pick_mode(), 1'($urandom_range(1)), random_word()));
         random_sent++;
      end
      if ($urandom_range(4) != 0) begin
         send(with_opcode(OP_SET_COMBINE, combine_body()));
         random_sent++;
      end
      n = $urandom_range(6, 1);
      repeat (n) begin
         send(with_opcode(draw_opcode(), random_word()));
         random_sent++;
      end
   endtask

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.command_word = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // draw with nothing set up, then the all-zero and all-one words
      send(with_opcode(OP_TRI_FIRST, random_word()));
      send('0);
      send('1);
      // mode change before any combine
      send(modes_word(CM_ONE_CYCLE, 1'b0, '0));
      send(with_opcode(OP_TEX_RECT, random_word()));
      send(with_opcode(OP_SET_SCISSOR, '1));
      // identical cycles, first clean then on the combined slot
      send(with_opcode(OP_SET_COMBINE, '1));
      send(with_opcode(OP_TRI_SHADE_TEX_Z, '1));
      send(with_opcode(OP_SET_COMBINE, '0));
      send(with_opcode(OP_TRI_FIRST, '0));
      send(with_opcode(OP_SET_COMBINE, combine_body()));
      send(with_opcode(OP_TEX_RECT_FLIP, random_word()));
      send(with_opcode(OP_FILL_RECT, random_word()));
      // cycle mode 1 with perspective, textured with and without depth
      send(modes_word(CM_TWO_CYCLE, 1'b1, random_word()));
      send(with_opcode(tri_opcode(1'b0, 1'b1, 1'b0), random_word()));
      send(with_opcode(tri_opcode(1'b0, 1'b1, 1'b1), random_word()));
      send(with_opcode(tri_opcode(1'b1, 1'b0, 1'b0), random_word()));
      // copy and fill modes
      send(modes_word(CM_COPY, 1'b0, random_word()));
      send(with_opcode(OP_TEX_RECT_FLIP, random_word()));
      send(with_opcode(OP_TEX_RECT, random_word()));
      send(with_opcode(tri_opcode(1'b1, 1'b0, 1'b1), random_word()));
      send(modes_word(CM_FILL, 1'b1, '1));
      send(with_opcode(OP_FILL_RECT, '1));
      send(with_opcode(tri_opcode(1'b1, 1'b1, 1'b0), random_word()));
      drain();

      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(7) == 0) steady = ~steady;
         play_scene();
         if ($urandom_range(39) == 0) drain();
      end
      drain();
      // leave margin for strays after the drain
      repeat (8) @(negedge clock);

      $display("summary: %0d draws, %0d state updates, %0d other words, %0d results checked",
               draws_sent, setup_sent, noise_sent, checked);
      $display("summary: all four cycle modes, sparse and dense combiners, %0d drain pauses",
               drains);
      if (mismatches == 0)
         $display("render_command_validator_test: done, clean");
      else
         $display("render_command_validator_test: done, errors");
      $finish;
   end

endmodule

### files.f
src/rcv_pkg.sv
src/rcv_if.sv
src/rcv_checker.sv
src/rcv_totals.sv
src/render_command_validator.sv
tb/validator_scoreboard.sv
tb/render_command_validator_test.sv
